// ----- design/dta_pkg.sv -----
// Shared types, constants and arctangent table for the direction to Euler angle block.
package dta_pkg;

  localparam int CORDIC_STAGES = 24;
  localparam int FRACTION_BITS = 16;
  localparam int ANG_FRAC      = 24;
  localparam int ANG_W         = 34;
  localparam int OUT_W         = 25;
  localparam int THR_W         = 17;
  localparam int ADDR_W        = 3;
  localparam int SQRT_STEPS    = 32;
  localparam int FRONT_STAGES  = SQRT_STEPS + 3;
  localparam int CORDIC_LAT    = CORDIC_STAGES + 9;
  localparam int DTA_LAT       = FRONT_STAGES + CORDIC_LAT;

  localparam logic [THR_W-1:0] THR_RESET = THR_W'(66);

  localparam logic signed [ANG_W-1:0] ANG_90  = ANG_W'(90) <<< ANG_FRAC;
  localparam logic signed [ANG_W-1:0] ANG_180 = ANG_W'(180) <<< ANG_FRAC;
  localparam logic signed [ANG_W-1:0] ANG_270 = ANG_W'(270) <<< ANG_FRAC;
  localparam logic signed [ANG_W-1:0] ANG_360 = ANG_W'(360) <<< ANG_FRAC;

  localparam logic [OUT_W-1:0] OUT_FULL_TURN = OUT_W'(360) << FRACTION_BITS;

  // atan(2^-i) in degrees, 24 fraction bits
  localparam logic [29:0] ATAN_DEG [32] = '{
    30'd754974720, 30'd445687602, 30'd235489088, 30'd119537938, 30'd60000934,
    30'd30029717,  30'd15018523,  30'd7509720,   30'd3754917,   30'd1877466,
    30'd938734,    30'd469367,    30'd234684,    30'd117342,    30'd58671,
    30'd29335,     30'd14668,     30'd7334,      30'd3667,      30'd1833,
    30'd917,       30'd458,       30'd229,       30'd115,       30'd57,
    30'd29,        30'd14,        30'd7,         30'd4,         30'd2,
    30'd1,         30'd0
  };

  typedef enum logic [1:0] {
    QD_0,
    QD_90,
    QD_180,
    QD_270
  } quad_t;

  typedef struct packed {
    logic signed [31:0] dir_x;
    logic signed [31:0] dir_y;
    logic signed [31:0] dir_z;
    logic               use_up_vector;
    logic signed [31:0] up_x;
    logic signed [31:0] up_y;
    logic signed [31:0] up_z;
  } dta_req_t;

  typedef struct packed {
    logic [OUT_W-1:0] pitch_deg;
    logic [OUT_W-1:0] yaw_deg;
    logic [OUT_W-1:0] roll_deg;
  } dta_res_t;

endpackage

// ----- design/dta_cordic.sv -----
// Pipelined CORDIC atan2 over 64-bit operands, result in degrees wrapped to [0,360).
module dta_cordic (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_vld,
  input  logic signed [63:0]              in_y,
  input  logic signed [63:0]              in_x,
  output logic                            out_vld,
  output logic [dta_pkg::OUT_W-1:0]       out_ang
);

  localparam int NS = dta_pkg::CORDIC_STAGES;
  localparam int SH = dta_pkg::ANG_FRAC - dta_pkg::FRACTION_BITS;
  localparam int ANG_W_M1 = dta_pkg::ANG_W - 2;

  typedef struct packed {
    logic           sp;
    dta_pkg::quad_t spq;
    logic           base;
  } side_t;

  typedef struct packed {
    side_t       sd;
    logic        yneg;
    logic [63:0] m;
    logic [63:0] mx;
    logic [63:0] my;
  } pre_t;

  typedef struct packed {
    side_t              sd;
    logic [31:0]        x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } cs_t;

  logic signed [63:0] y_in_r, x_in_r;
  logic               vin_r;
  pre_t               pre_r [1:5];
  logic               vpre_r [1:5];
  pre_t               pre1_nxt;
  pre_t               pre2_nxt;
  cs_t                cs_r [0:NS];
  logic               vcs_r [0:NS];
  cs_t                cs0_nxt;
  logic [ANG_W_M1:0]  ang_r;
  logic               vang_r;
  logic [dta_pkg::OUT_W-1:0] out_ang_r;
  logic               vout_r;

  function automatic logic [63:0] mag64(input logic signed [63:0] v);
    return v[63] ? 64'(-v) : 64'(v);
  endfunction

  // shift left until the larger magnitude has its top bit set
  function automatic pre_t nrm_step(input pre_t p, input int k);
    pre_t r;
    r = p;
    if ((p.m >> (64 - k)) == 64'd0) begin
      r.m  = p.m << k;
      r.mx = p.mx << k;
      r.my = p.my << k;
    end
    return r;
  endfunction

  always_comb begin
    pre1_nxt.sd.sp   = (y_in_r == 64'sd0) || (x_in_r == 64'sd0);
    if (y_in_r == 64'sd0) begin
      pre1_nxt.sd.spq = x_in_r[63] ? dta_pkg::QD_180 : dta_pkg::QD_0;
    end else begin
      pre1_nxt.sd.spq = y_in_r[63] ? dta_pkg::QD_270 : dta_pkg::QD_90;
    end
    pre1_nxt.sd.base = x_in_r[63];
    // after the half-turn flip the y sign follows the wrapped negation
    if (x_in_r[63]) begin
      pre1_nxt.yneg = !y_in_r[63] || (y_in_r == {1'b1, 63'd0});
    end else begin
      pre1_nxt.yneg = y_in_r[63];
    end
    pre1_nxt.m  = 64'd0;
    pre1_nxt.mx = mag64(x_in_r);
    pre1_nxt.my = mag64(y_in_r);
  end

  always_comb begin
    pre2_nxt   = pre_r[1];
    pre2_nxt.m = (pre_r[1].mx > pre_r[1].my) ? pre_r[1].mx : pre_r[1].my;
  end

  always_comb begin
    logic [31:0] ym;
    ym = 32'(pre_r[5].my[63:35]);
    cs0_nxt.sd = pre_r[5].sd;
    cs0_nxt.x  = 32'(pre_r[5].mx[63:35]);
    cs0_nxt.y  = pre_r[5].yneg ? $signed(-ym) : $signed(ym);
    cs0_nxt.z  = 32'sd0;
  end

  always_ff @(posedge clk) begin
    y_in_r <= in_y;
    x_in_r <= in_x;
    pre_r[1] <= pre1_nxt;
    pre_r[2] <= pre2_nxt;
    pre_r[3] <= nrm_step(nrm_step(pre_r[2], 32), 16);
    pre_r[4] <= nrm_step(nrm_step(pre_r[3], 8), 4);
    pre_r[5] <= nrm_step(nrm_step(pre_r[4], 2), 1);
    cs_r[0]  <= cs0_nxt;
    if (!rst_n) begin
      vin_r   <= 1'b0;
      vpre_r  <= '{default: 1'b0};
      vcs_r[0] <= 1'b0;
    end else begin
      vin_r     <= in_vld;
      vpre_r[1] <= vin_r;
      for (int k = 2; k <= 5; k++) vpre_r[k] <= vpre_r[k-1];
      vcs_r[0]  <= vpre_r[5];
    end
  end

  for (genvar i = 0; i < NS; i++) begin : g_stage
    logic [31:0] ay;
    cs_t         cs_nxt;
    always_comb begin
      ay = cs_r[i].y[31] ? 32'(-cs_r[i].y) : 32'(cs_r[i].y);
      cs_nxt   = cs_r[i];
      cs_nxt.x = cs_r[i].x + (ay >> i);
      if (!cs_r[i].y[31]) begin
        cs_nxt.y = cs_r[i].y - $signed(cs_r[i].x >> i);
        cs_nxt.z = cs_r[i].z + $signed({2'b00, dta_pkg::ATAN_DEG[i]});
      end else begin
        cs_nxt.y = cs_r[i].y + $signed(cs_r[i].x >> i);
        cs_nxt.z = cs_r[i].z - $signed({2'b00, dta_pkg::ATAN_DEG[i]});
      end
    end
    always_ff @(posedge clk) begin
      cs_r[i+1] <= cs_nxt;
      if (!rst_n) begin
        vcs_r[i+1] <= 1'b0;
      end else begin
        vcs_r[i+1] <= vcs_r[i];
      end
    end
  end

  // add the half-turn base, wrap, or take the axis angle
  logic signed [dta_pkg::ANG_W-1:0] sum, ang_nxt;
  always_comb begin
    sum = (cs_r[NS].sd.base ? dta_pkg::ANG_180 : '0) + dta_pkg::ANG_W'(cs_r[NS].z);
    if (sum < 0) begin
      sum = sum + dta_pkg::ANG_360;
    end else if (sum >= dta_pkg::ANG_360) begin
      sum = sum - dta_pkg::ANG_360;
    end
    ang_nxt = sum;
    if (cs_r[NS].sd.sp) begin
      case (cs_r[NS].sd.spq)
        dta_pkg::QD_0:   ang_nxt = '0;
        dta_pkg::QD_90:  ang_nxt = dta_pkg::ANG_90;
        dta_pkg::QD_180: ang_nxt = dta_pkg::ANG_180;
        dta_pkg::QD_270: ang_nxt = dta_pkg::ANG_270;
        default:         ang_nxt = '0;
      endcase
    end
  end

  // round half up to the output fraction, fold a full turn back to zero
  logic [dta_pkg::ANG_W-1:0] rq;
  logic [dta_pkg::OUT_W-1:0] rnd;
  always_comb begin
    rq  = ((({1'b0, ang_r} << 1) >> SH) + dta_pkg::ANG_W'(1)) >> 1;
    rnd = dta_pkg::OUT_W'(rq);
    if (rq >= dta_pkg::ANG_W'(dta_pkg::OUT_FULL_TURN)) begin
      rnd = dta_pkg::OUT_W'(rq - dta_pkg::ANG_W'(dta_pkg::OUT_FULL_TURN));
    end
  end

  always_ff @(posedge clk) begin
    ang_r     <= ang_nxt[ANG_W_M1:0];
    out_ang_r <= rnd;
    if (!rst_n) begin
      vang_r <= 1'b0;
      vout_r <= 1'b0;
    end else begin
      vang_r <= vcs_r[NS];
      vout_r <= vang_r;
    end
  end

  assign out_vld = vout_r;
  assign out_ang = out_ang_r;

endmodule

// ----- design/direction_to_euler_angles.sv -----
// Top level: direction vector and optional up vector to pitch, yaw and roll in degrees.
//
// Requests enter on start/in_req; a request is taken at a rising edge where start is
// high and busy is low. busy is high only while reset is applied, so after reset one
// request can enter every cycle. Each request yields exactly one result: out_valid
// pulses for one cycle with out_res once the request has passed 35 front stages
// (squares and cross products, 32-step square root, left-vector scaling and roll
// operands) and then 33 stages of CORDIC atan2 (setup, normalize, 24 rotation
// stages, wrap and rounding). Throughput is one request per cycle.
// The receiver cannot stall, so nothing is ever held back.
// horizontal_threshold sits at byte address 0 of the APB-style port (reset 66);
// change it only while no request is in flight. Reset clears every valid bit, so
// requests in flight at reset are dropped; pipeline data is not cleared.
module direction_to_euler_angles (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  dta_pkg::dta_req_t               in_req,
  output logic                            out_valid,
  output dta_pkg::dta_res_t               out_res,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [dta_pkg::ADDR_W-1:0]      paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);

  localparam int  FS      = dta_pkg::FRONT_STAGES;
  localparam int  NQ      = dta_pkg::SQRT_STEPS;
  localparam logic REG_THR = 1'b0;

  typedef struct packed {
    logic signed [31:0] dx;
    logic signed [31:0] dy;
    logic signed [31:0] dz;
    logic               use_up;
  } dir_t;

  typedef struct packed {
    logic signed [31:0] ux;
    logic signed [31:0] uy;
    logic signed [31:0] uz;
  } upv_t;

  typedef struct packed {
    logic [63:0]        dxx;
    logic [63:0]        dyy;
    logic signed [63:0] uydz;
    logic signed [63:0] uzdy;
    logic signed [63:0] uzdx;
    logic signed [63:0] uxdz;
    logic signed [63:0] uxdy;
    logic signed [63:0] uydx;
  } prd_t;

  typedef struct packed {
    logic signed [63:0] lx;
    logic signed [63:0] ly;
    logic signed [63:0] lz;
  } crs_t;

  typedef struct packed {
    logic signed [63:0] lxn;
    logic signed [63:0] ly;
  } lft_t;

  typedef struct packed {
    logic [63:0] m;
    logic [63:0] mx;
    logic [63:0] my;
    logic [63:0] mz;
    logic        sx;
    logic        sy;
    logic        sz;
  } scl_t;

  typedef struct packed {
    logic signed [30:0] lxs;
    logic signed [30:0] lys;
    logic signed [30:0] lzs;
  } lsc_t;

  typedef struct packed {
    logic signed [63:0] rx;
    logic signed [63:0] ry;
  } rol_t;

  logic                      busy_r;
  logic [dta_pkg::THR_W-1:0] thr_r;
  logic                      vld_r [1:FS];
  dir_t                      dir_r [1:FS];
  upv_t                      up_r;
  prd_t                      prd_r;
  crs_t                      crs_r;
  lft_t                      lft_r [3:FS];
  logic [63:0]               sqv_r [0:NQ];
  logic [63:0]               sqr_r [0:NQ];
  scl_t                      scl_r [4:8];
  scl_t                      scl5_nxt;
  lsc_t                      lsc_r;
  logic signed [63:0]        p1_r, p2_r;
  logic signed [30:0]        lz10_r;
  rol_t                      rol_r [11:FS];

  function automatic logic signed [63:0] smul(input logic signed [31:0] a,
                                              input logic signed [31:0] b);
    return 64'(a) * 64'(b);
  endfunction

  function automatic logic [63:0] mag64(input logic signed [63:0] v);
    return v[63] ? 64'(-v) : 64'(v);
  endfunction

  // drop k bits from every magnitude if the largest reaches 2^(29+k); it ends below 2^30
  function automatic scl_t scl_step(input scl_t s, input int k);
    scl_t r;
    r = s;
    if ((s.m >> (29 + k)) != 64'd0) begin
      r.m  = s.m >> k;
      r.mx = s.mx >> k;
      r.my = s.my >> k;
      r.mz = s.mz >> k;
    end
    return r;
  endfunction

  // config port: one register, word address decoded on paddr's top bit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r  <= dta_pkg::THR_RESET;
      busy_r <= 1'b1;
    end else begin
      busy_r <= 1'b0;
      if (psel && penable && pwrite && (paddr[dta_pkg::ADDR_W-1] == REG_THR)) begin
        thr_r <= pwdata[dta_pkg::THR_W-1:0];
      end
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[dta_pkg::ADDR_W-1] == REG_THR) ? 32'(thr_r) : 32'd0;
  assign busy   = busy_r;

  // valid bits advance every cycle; nothing downstream can hold them
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '{default: 1'b0};
    end else begin
      vld_r[1] <= start && !busy_r;
      for (int k = 2; k <= FS; k++) vld_r[k] <= vld_r[k-1];
    end
  end

  // stage 1: capture the request; stage 2: products; stage 3: sum and cross product
  always_ff @(posedge clk) begin
    dir_r[1].dx     <= in_req.dir_x;
    dir_r[1].dy     <= in_req.dir_y;
    dir_r[1].dz     <= in_req.dir_z;
    dir_r[1].use_up <= in_req.use_up_vector;
    up_r.ux         <= in_req.up_x;
    up_r.uy         <= in_req.up_y;
    up_r.uz         <= in_req.up_z;
    for (int k = 2; k <= FS; k++) dir_r[k] <= dir_r[k-1];

    prd_r.dxx  <= 64'(smul(dir_r[1].dx, dir_r[1].dx));
    prd_r.dyy  <= 64'(smul(dir_r[1].dy, dir_r[1].dy));
    prd_r.uydz <= smul(up_r.uy, dir_r[1].dz);
    prd_r.uzdy <= smul(up_r.uz, dir_r[1].dy);
    prd_r.uzdx <= smul(up_r.uz, dir_r[1].dx);
    prd_r.uxdz <= smul(up_r.ux, dir_r[1].dz);
    prd_r.uxdy <= smul(up_r.ux, dir_r[1].dy);
    prd_r.uydx <= smul(up_r.uy, dir_r[1].dx);

    sqv_r[0] <= prd_r.dxx + prd_r.dyy;
    sqr_r[0] <= 64'd0;
    crs_r.lx <= prd_r.uydz - prd_r.uzdy;
    crs_r.ly <= prd_r.uzdx - prd_r.uxdz;
    crs_r.lz <= prd_r.uxdy - prd_r.uydx;
    lft_r[3].lxn <= prd_r.uzdy - prd_r.uydz;
    lft_r[3].ly  <= prd_r.uzdx - prd_r.uxdz;
    for (int k = 4; k <= FS; k++) lft_r[k] <= lft_r[k-1];
  end

  // square root of the horizontal length squared, one result bit per stage
  for (genvar j = 0; j < NQ; j++) begin : g_sqrt
    localparam logic [63:0] BIT = 64'd1 << (62 - 2 * j);
    logic [63:0] trial;
    assign trial = sqr_r[j] + BIT;
    always_ff @(posedge clk) begin
      if (sqv_r[j] >= trial) begin
        sqv_r[j+1] <= sqv_r[j] - trial;
        sqr_r[j+1] <= (sqr_r[j] >> 1) + BIT;
      end else begin
        sqv_r[j+1] <= sqv_r[j];
        sqr_r[j+1] <= sqr_r[j] >> 1;
      end
    end
  end

  // largest left-vector magnitude for the scaling stages
  always_comb begin
    scl5_nxt = scl_r[4];
    if (scl_r[4].mx >= scl_r[4].my && scl_r[4].mx >= scl_r[4].mz) begin
      scl5_nxt.m = scl_r[4].mx;
    end else if (scl_r[4].my >= scl_r[4].mz) begin
      scl5_nxt.m = scl_r[4].my;
    end else begin
      scl5_nxt.m = scl_r[4].mz;
    end
  end

  // left vector scaling and roll operands, stages 4 to 11
  always_ff @(posedge clk) begin
    scl_r[4].m  <= 64'd0;
    scl_r[4].mx <= mag64(crs_r.lx);
    scl_r[4].my <= mag64(crs_r.ly);
    scl_r[4].mz <= mag64(crs_r.lz);
    scl_r[4].sx <= crs_r.lx[63];
    scl_r[4].sy <= crs_r.ly[63];
    scl_r[4].sz <= crs_r.lz[63];

    scl_r[5] <= scl5_nxt;

    scl_r[6] <= scl_step(scl_step(scl_r[5], 32), 16);
    scl_r[7] <= scl_step(scl_step(scl_r[6], 8), 4);
    scl_r[8] <= scl_step(scl_step(scl_r[7], 2), 1);

    lsc_r.lxs <= scl_r[8].sx ? -$signed(31'(scl_r[8].mx)) : $signed(31'(scl_r[8].mx));
    lsc_r.lys <= scl_r[8].sy ? -$signed(31'(scl_r[8].my)) : $signed(31'(scl_r[8].my));
    lsc_r.lzs <= scl_r[8].sz ? -$signed(31'(scl_r[8].mz)) : $signed(31'(scl_r[8].mz));

    p1_r   <= smul(dir_r[9].dx, 32'(lsc_r.lys));
    p2_r   <= smul(dir_r[9].dy, 32'(lsc_r.lxs));
    lz10_r <= lsc_r.lzs;

    rol_r[11].rx <= p1_r - p2_r;
    rol_r[11].ry <= 64'(lz10_r) <<< dta_pkg::FRACTION_BITS;
    for (int k = 12; k <= FS; k++) rol_r[k] <= rol_r[k-1];
  end

  // pick the atan2 operands once the horizontal length is known
  logic [31:0]        len;
  logic               long_h;
  logic               vert0;
  logic signed [63:0] pit_y, pit_x, yaw_y, yaw_x, rol_y, rol_x;
  dir_t               df;

  always_comb begin
    df     = dir_r[FS];
    len    = sqr_r[NQ][31:0];
    long_h = df.use_up && (len > 32'(thr_r));
    vert0  = !df.use_up && (df.dx == 32'sd0) && (df.dy == 32'sd0) && (df.dz == 32'sd0);
    // a zero vector without up reads as straight down: 90 degrees
    pit_y  = vert0 ? 64'sd1 : -64'(df.dz);
    pit_x  = $signed(64'(len));
    if (df.use_up && !long_h) begin
      yaw_y = lft_r[FS].lxn;
      yaw_x = lft_r[FS].ly;
    end else begin
      yaw_y = 64'(df.dy);
      yaw_x = 64'(df.dx);
    end
    rol_y = long_h ? rol_r[FS].ry : 64'sd0;
    rol_x = long_h ? rol_r[FS].rx : 64'sd0;
  end

  logic pit_v, yaw_v, rol_v;

  dta_cordic u_pitch (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (vld_r[FS]),
    .in_y    (pit_y),
    .in_x    (pit_x),
    .out_vld (pit_v),
    .out_ang (out_res.pitch_deg)
  );

  dta_cordic u_yaw (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (vld_r[FS]),
    .in_y    (yaw_y),
    .in_x    (yaw_x),
    .out_vld (yaw_v),
    .out_ang (out_res.yaw_deg)
  );

  dta_cordic u_roll (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (vld_r[FS]),
    .in_y    (rol_y),
    .in_x    (rol_x),
    .out_vld (rol_v),
    .out_ang (out_res.roll_deg)
  );

  assign out_valid = pit_v && yaw_v && rol_v;

endmodule

// ----- design/dta_checker.sv -----
// Port-level checks for the direction to Euler angle block, bound to the top level.
module dta_props (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       start,
  input logic                       busy,
  input dta_pkg::dta_req_t          in_req,
  input logic                       out_valid,
  input dta_pkg::dta_res_t          out_res
);

  localparam int LAT = dta_pkg::DTA_LAT;
  localparam int AW  = $clog2(LAT + 1);

  logic [AW-1:0] age_r;

  // count cycles since reset until the pipeline is fully refilled
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      age_r <= '0;
    end else if (age_r != AW'(LAT)) begin
      age_r <= age_r + AW'(1);
    end
  end

  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_res.pitch_deg < dta_pkg::OUT_FULL_TURN) &&
                  (out_res.yaw_deg < dta_pkg::OUT_FULL_TURN) &&
                  (out_res.roll_deg < dta_pkg::OUT_FULL_TURN))
    else $error("angle outside one turn");

  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    (age_r == AW'(LAT)) |-> (out_valid == $past(start && !busy, LAT)))
    else $error("result count does not follow requests");

  a_no_roll: assert property (@(posedge clk) disable iff (!rst_n)
    (age_r == AW'(LAT)) && out_valid && !$past(in_req.use_up_vector, LAT)
      |-> (out_res.roll_deg == '0))
    else $error("roll set without up vector");

  a_zero_dir: assert property (@(posedge clk) disable iff (!rst_n)
    (age_r == AW'(LAT)) && out_valid &&
    $past(!in_req.use_up_vector && (in_req.dir_x == 32'sd0) &&
          (in_req.dir_y == 32'sd0) && (in_req.dir_z == 32'sd0), LAT)
      |-> (out_res.pitch_deg == (dta_pkg::OUT_W'(90) << dta_pkg::FRACTION_BITS)) &&
          (out_res.yaw_deg == '0))
    else $error("zero direction angles wrong");

endmodule

bind direction_to_euler_angles dta_props u_dta_props (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_req    (in_req),
  .out_valid (out_valid),
  .out_res   (out_res)
);

// ----- tb/dta_checker.sv -----
// Checker for the direction to Euler angle block: predicts each request's angles and compares.
`timescale 1ns / 100ps

module dta_checker (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic                    busy,
  input  dta_pkg::dta_req_t       in_req,
  input  logic                    out_valid,
  input  dta_pkg::dta_res_t       out_res,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic                    pready,
  input  logic [dta_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]             pwdata,
  output int                      fail_count,
  output int                      angles_pending
);
  import dta_pkg::*;

  localparam longint ONE_DEG = longint'(1) << ANG_FRAC;
  localparam logic [ADDR_W-1:0] THR_ADDR = '0;

  logic [THR_W-1:0] thr_shadow;
  dta_res_t         angles_q[$];

  function automatic longint unsigned mag(longint v);
    return v < 0 ? longint'(0) - v : v;
  endfunction

  function automatic longint signed_of(longint unsigned m, bit neg);
    return neg ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint trunc_shr(longint v, int unsigned s);
    if (s > 63) return 0;
    return signed_of(mag(v) >> s, v < 0);
  endfunction

  function automatic longint unsigned floor_sqrt(longint unsigned v);
    longint unsigned res, b;
    res = 0;
    b = longint'(1) << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  // vectoring CORDIC, degrees with 24 fraction bits in [0,360)
  function automatic longint atan2_deg(longint y, longint x);
    longint base, z, nx, ny, sum;
    longint unsigned mx, my, m;
    base = 0;
    z = 0;
    if (y == 0) return x < 0 ? 180 * ONE_DEG : 0;
    if (x == 0) return y > 0 ? 90 * ONE_DEG : 270 * ONE_DEG;
    if (x < 0) begin
      x = -x;
      y = -y;
      base = 180 * ONE_DEG;
    end
    mx = mag(x);
    my = mag(y);
    m = mx > my ? mx : my;
    while (m >= (longint'(1) << 29)) begin
      m >>= 1; mx >>= 1; my >>= 1;
    end
    while (m < (longint'(1) << 28)) begin
      m <<= 1; mx <<= 1; my <<= 1;
    end
    x = longint'(mx);
    y = signed_of(my, y < 0);
    for (int i = 0; i < CORDIC_STAGES; i++) begin
      if (y >= 0) begin
        nx = x + trunc_shr(y, i);
        ny = y - trunc_shr(x, i);
        z += longint'(ATAN_DEG[i % 32]);
      end else begin
        nx = x - trunc_shr(y, i);
        ny = y + trunc_shr(x, i);
        z -= longint'(ATAN_DEG[i % 32]);
      end
      x = nx;
      y = ny;
    end
    sum = base + z;
    if (sum < 0) sum += 360 * ONE_DEG;
    if (sum >= 360 * ONE_DEG) sum -= 360 * ONE_DEG;
    return sum;
  endfunction

  function automatic logic [OUT_W-1:0] round_deg(longint ang);
    longint unsigned t, r;
    t = longint'(ang) << 1;
    r = ((t >> (ANG_FRAC - FRACTION_BITS)) + 1) >> 1;
    if (r >= (longint'(360) << FRACTION_BITS)) r -= longint'(360) << FRACTION_BITS;
    return r[OUT_W-1:0];
  endfunction

  function automatic dta_res_t predict_angles(dta_req_t r, logic [THR_W-1:0] thr);
    longint dx, dy, dz, ux, uy, uz, lx, ly, lz, len, pitch, yaw, roll;
    longint unsigned m;
    int unsigned s;
    dta_res_t res;
    dx = longint'(r.dir_x);
    dy = longint'(r.dir_y);
    dz = longint'(r.dir_z);
    yaw = 0;
    roll = 0;
    len = longint'(floor_sqrt(longint'(dx * dx) + longint'(dy * dy)));
    if (!r.use_up_vector) begin
      if (dx == 0 && dy == 0) begin
        pitch = (dz > 0 ? 270 : 90) * ONE_DEG;
      end else begin
        pitch = atan2_deg(-dz, len);
        yaw = atan2_deg(dy, dx);
      end
    end else begin
      ux = longint'(r.up_x);
      uy = longint'(r.up_y);
      uz = longint'(r.up_z);
      lx = uy * dz - uz * dy;
      ly = uz * dx - ux * dz;
      lz = ux * dy - uy * dx;
      pitch = atan2_deg(-dz, len);
      if (longint'(len) > longint'(thr)) begin
        m = mag(lx);
        if (mag(ly) > m) m = mag(ly);
        if (mag(lz) > m) m = mag(lz);
        s = 0;
        while ((m >> s) >= (longint'(1) << 30)) s++;
        lx = trunc_shr(lx, s);
        ly = trunc_shr(ly, s);
        lz = trunc_shr(lz, s);
        yaw = atan2_deg(dy, dx);
        roll = atan2_deg(lz * (longint'(1) << FRACTION_BITS), dx * ly - dy * lx);
      end else begin
        yaw = atan2_deg(-lx, ly);
      end
    end
    res.pitch_deg = round_deg(pitch);
    res.yaw_deg   = round_deg(yaw);
    res.roll_deg  = round_deg(roll);
    return res;
  endfunction

  always @(posedge clk) begin
    dta_res_t want;
    if (!rst_n) begin
      thr_shadow = THR_RESET;
      angles_q.delete();
      fail_count = 0;
      angles_pending = 0;
    end else begin
      if (psel && penable && pwrite && pready && paddr == THR_ADDR)
        thr_shadow = pwdata[THR_W-1:0];
      if (start && !busy) angles_q.push_back(predict_angles(in_req, thr_shadow));
      if (out_valid) begin
        if (angles_q.size() == 0) begin
          $error("result with no request outstanding");
          fail_count++;
        end else begin
          want = angles_q.pop_front();
          if (out_res.pitch_deg !== want.pitch_deg) begin
            $error("pitch_deg expected %0d got %0d", want.pitch_deg, out_res.pitch_deg);
            fail_count++;
          end
          if (out_res.yaw_deg !== want.yaw_deg) begin
            $error("yaw_deg expected %0d got %0d", want.yaw_deg, out_res.yaw_deg);
            fail_count++;
          end
          if (out_res.roll_deg !== want.roll_deg) begin
            $error("roll_deg expected %0d got %0d", want.roll_deg, out_res.roll_deg);
            fail_count++;
          end
        end
      end
      angles_pending = angles_q.size();
    end
  end

endmodule

// ----- tb/direction_to_euler_angles_tb.sv -----
// Testbench top: drives requests and threshold writes into the block and gives the verdict.
`timescale 1ns / 100ps

module direction_to_euler_angles_tb;
  import dta_pkg::*;

  localparam logic [ADDR_W-1:0] THR_ADDR = '0;
  localparam int DRAIN_CYCLES = DTA_LAT + 32;

  logic              clk;
  logic              rst_n;
  logic              start;
  logic              busy;
  dta_req_t          in_req;
  logic              out_valid;
  dta_res_t          out_res;
  logic              psel, penable, pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;
  int                fail_count;
  int                angles_pending;
  int                idle_pct;

  direction_to_euler_angles uut (
    .clk, .rst_n, .start, .busy, .in_req, .out_valid, .out_res,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  dta_checker checker_i (
    .clk, .rst_n, .start, .busy, .in_req, .out_valid, .out_res,
    .psel, .penable, .pwrite, .pready, .paddr, .pwdata,
    .fail_count, .angles_pending
  );

  // 8 ns clock
  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // hard stop in case the pipeline hangs
  initial begin
    #4000000;
    $display("Regression FAIL");
    $finish;
  end

  // hold the request line low until every predicted result has come back
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (angles_pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // APB write of the threshold, setup phase then access phase; the block must be idle
  task automatic write_threshold(logic [THR_W-1:0] thr);
    drain();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= THR_ADDR;
    pwdata  <= 32'(thr);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // issue one request, idling the sender at random first; return once it is taken
  task automatic send_request(dta_req_t r);
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < idle_pct) @(posedge clk);
    end
    start  <= 1'b1;
    in_req <= r;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // one component: full range, tiny, around unit length, or zero
  function automatic logic signed [31:0] rand_comp();
    int sel;
    logic signed [31:0] v;
    sel = $urandom_range(9);
    if (sel < 3) v = $urandom;
    else if (sel < 5) v = $urandom_range(300);
    else if (sel < 8) v = $urandom_range(200000);
    else if (sel < 9) v = $urandom_range(32'h7fffffff);
    else v = 0;
    return ($urandom_range(1) != 0) ? -v : v;
  endfunction

  function automatic dta_req_t rand_request();
    dta_req_t r;
    r.dir_x = rand_comp();
    r.dir_y = rand_comp();
    r.dir_z = rand_comp();
    r.use_up_vector = ($urandom_range(99) < 65);
    r.up_x = rand_comp();
    r.up_y = rand_comp();
    r.up_z = rand_comp();
    // now and then make up parallel to the direction
    if ($urandom_range(19) == 0) begin
      r.up_x = r.dir_x;
      r.up_y = r.dir_y;
      r.up_z = r.dir_z;
    end
    return r;
  endfunction

  function automatic dta_req_t mk(int dx, int dy, int dz, bit up, int ux, int uy, int uz);
    dta_req_t r;
    r.dir_x = dx; r.dir_y = dy; r.dir_z = dz;
    r.use_up_vector = up;
    r.up_x = ux; r.up_y = uy; r.up_z = uz;
    return r;
  endfunction

  initial begin
    localparam int MAX_I = 32'h7fffffff;
    localparam int MIN_I = 32'h80000000;
    dta_req_t directed[$];
    logic [THR_W-1:0] thr_plan[5];
    int pct_plan[4];

    rst_n   = 1'b0;
    start   = 1'b0;
    in_req  = '0;
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = '0;
    pwdata  = '0;
    idle_pct = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed requests under the reset threshold
    directed.push_back(mk(0, 0, 65536, 0, 0, 0, 0));          // straight up: pitch 270
    directed.push_back(mk(0, 0, -65536, 0, 0, 0, 0));         // straight down: pitch 90
    directed.push_back(mk(0, 0, 0, 0, 0, 0, 0));              // zero direction
    directed.push_back(mk(0, 0, 0, 1, 65536, 0, 0));          // zero direction with up
    directed.push_back(mk(65536, 0, 0, 0, 0, 0, 0));
    directed.push_back(mk(-65536, 0, 0, 0, 0, 0, 0));         // yaw 180
    directed.push_back(mk(0, -65536, 0, 0, 0, 0, 0));         // yaw 270
    directed.push_back(mk(65536, -1, 0, 0, 0, 0, 0));         // rounds to a full turn
    directed.push_back(mk(MAX_I, MAX_I, MAX_I, 0, 0, 0, 0));
    directed.push_back(mk(MIN_I, MIN_I, MIN_I, 0, 0, 0, 0));
    directed.push_back(mk(MIN_I, MIN_I, MIN_I, 1, MAX_I, MIN_I, MAX_I)); // left scaled
    directed.push_back(mk(MAX_I, MIN_I, MAX_I, 1, MIN_I, MAX_I, MIN_I));
    directed.push_back(mk(65536, 0, 0, 1, 0, 0, 65536));      // level, roll 0
    directed.push_back(mk(65536, 0, 0, 1, 0, 65536, 0));     // rolled, roll 270
    directed.push_back(mk(65536, 65536, 0, 1, 65536, 65536, 0)); // up parallel
    directed.push_back(mk(65536, 0, 0, 1, 0, 0, 0));          // zero up vector
    directed.push_back(mk(66, 0, 1000, 1, 0, 65536, 0));      // length at threshold
    directed.push_back(mk(67, 0, 1000, 1, 0, 65536, 0));      // just above threshold
    directed.push_back(mk(3, 4, 65536, 1, 65536, 0, 0));      // near vertical, yaw from left
    directed.push_back(mk(-1, 1, -1, 1, 1, -1, 1));
    directed.push_back(mk(MAX_I, 0, 0, 1, 0, MIN_I, 0));
    foreach (directed[i]) send_request(directed[i]);

    // threshold settings: zero, full scale, above full scale, reset value, random
    thr_plan = '{THR_W'(0), THR_W'(65536), THR_W'(131071), THR_W'(66),
                 THR_W'($urandom_range(200))};
    pct_plan = '{0, 85, 21, 0};
    for (int ph = 0; ph < 5; ph++) begin
      write_threshold(thr_plan[ph]);
      idle_pct = pct_plan[ph % 4];
      for (int n = 0; n < 250; n++) begin
        // let the pipeline empty once mid-stream
        if (ph == 1 && n == 120) drain();
        // long burst with no gaps inside a phase that otherwise idles at random
        if (ph == 2 && n == 60) idle_pct = 0;
        if (ph == 2 && n == 140) idle_pct = pct_plan[2];
        send_request(rand_request());
      end
    end

    start <= 1'b0;
    @(posedge clk);
    while (angles_pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
design/dta_pkg.sv
design/dta_cordic.sv
design/direction_to_euler_angles.sv
design/dta_checker.sv
tb/dta_checker.sv
tb/direction_to_euler_angles_tb.sv
